### rtl/ptb_pkg.sv
package ptb_pkg;

    localparam int TICK_W  = 32;
    localparam int CFG_W   = 20;
    localparam int REM_W   = 21;
    localparam int ID_W    = 3;
    localparam int MASK_W  = 8;
    localparam int CIDX_W  = 2;

    localparam logic [CFG_W-1:0] CPTT_RESET = 20'd1000;
    localparam logic [CFG_W-1:0] CPTS_RESET = 20'd1000000;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_REGISTER = 2'd1,
        REQ_CHECK    = 2'd2
    } t_req;

    typedef enum logic [CIDX_W-1:0] {
        CFG_CPU_TICKS_PER_TICK   = 2'd0,
        CFG_CPU_TICKS_PER_SECOND = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic              do_tick;
        logic              do_reg;
        logic              do_check;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] end_tick;
        logic [TICK_W-1:0] period;
    } t_cell_cmd;

    typedef struct packed {
        logic fired;
        logic grant;
        logic was;
    } t_cell_rsp;

endpackage

### rtl/ptb_cell.sv
module ptb_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptb_pkg::t_cell_cmd i_cmd,
    input  logic               i_claim,
    output logic               o_claim,
    output ptb_pkg::t_cell_rsp o_rsp
);

    logic                       r_use;
    logic                       r_elapsed;
    logic [ptb_pkg::TICK_W-1:0] r_end;
    logic [ptb_pkg::TICK_W-1:0] r_period;

    logic fire;
    logic grant;
    logic sel;

    assign fire    = i_cmd.do_tick && r_use && (i_cmd.now >= r_end);
    assign grant   = i_cmd.do_reg && i_claim && !r_use;
    assign sel     = i_cmd.do_check && (int'(i_cmd.id) == IDX);
    assign o_claim = i_claim && r_use;

    assign o_rsp.fired = fire;
    assign o_rsp.grant = grant;
    assign o_rsp.was   = sel && r_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use     <= 1'b0;
            r_elapsed <= 1'b0;
        end else begin
            if (grant) begin
                r_use     <= 1'b1;
                r_elapsed <= 1'b0;
            end else if (fire) begin
                r_elapsed <= 1'b1;
            end else if (sel) begin
                r_elapsed <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (grant) begin
            r_end    <= i_cmd.end_tick;
            r_period <= i_cmd.period;
        end else if (fire) begin
            r_end <= r_end + r_period;
        end
    end

endmodule

### rtl/ptb_timebase.sv
module ptb_timebase (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ptb_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [ptb_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_advance,
    output logic [ptb_pkg::TICK_W-1:0] o_ticks_cur,
    output logic [ptb_pkg::TICK_W-1:0] o_ticks,
    output logic [ptb_pkg::TICK_W-1:0] o_seconds
);

    logic [ptb_pkg::CFG_W-1:0]  r_cptt;
    logic [ptb_pkg::CFG_W-1:0]  r_cpts;
    logic [ptb_pkg::TICK_W-1:0] r_ticks;
    logic [ptb_pkg::TICK_W-1:0] r_seconds;
    logic [ptb_pkg::REM_W-1:0]  r_rem;

    logic [ptb_pkg::REM_W:0]    sum;
    logic [ptb_pkg::REM_W:0]    sum_adj;
    logic                       wrap;
    logic [ptb_pkg::TICK_W-1:0] n_ticks;
    logic [ptb_pkg::TICK_W-1:0] n_seconds;
    logic [ptb_pkg::REM_W-1:0]  n_rem;

    always_comb begin
        sum       = {1'b0, r_rem} + {2'b00, r_cptt};
        wrap      = (sum >= {2'b00, r_cpts});
        sum_adj   = wrap ? (sum - {2'b00, r_cpts}) : sum;
        n_rem     = sum_adj[ptb_pkg::REM_W-1:0];
        n_ticks   = r_ticks + 32'd1;
        n_seconds = r_seconds + {31'd0, wrap};
    end

    assign o_ticks_cur = r_ticks;
    assign o_ticks     = i_advance ? n_ticks : r_ticks;
    assign o_seconds   = i_advance ? n_seconds : r_seconds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cptt <= ptb_pkg::CPTT_RESET;
            r_cpts <= ptb_pkg::CPTS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptb_pkg::CFG_CPU_TICKS_PER_TICK:   r_cptt <= i_cfg_data;
                ptb_pkg::CFG_CPU_TICKS_PER_SECOND: r_cpts <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks   <= '0;
            r_seconds <= '0;
            r_rem     <= '0;
        end else if (i_advance) begin
            r_ticks   <= n_ticks;
            r_seconds <= n_seconds;
            r_rem     <= n_rem;
        end
    end

endmodule

### rtl/periodic_timer_bank_core.sv
// A result is written to the output register at the clock edge that accepts its item.
// Throughput: one item per cycle while results are taken; every timer cell updates
// in the same cycle and the free-slot search ripples down the cell chain.
// Reset (synchronous, active low) clears the counts, the remainder and all slot flags,
// and restores both configuration registers to their default values.
module periodic_timer_bank_core #(
    parameter int NUM_TIMERS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ptb_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [ptb_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [ptb_pkg::ID_W-1:0]    i_timer_id,
    input  logic [ptb_pkg::TICK_W-1:0]  i_duration_ticks,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ptb_pkg::TICK_W-1:0]  o_tick_count,
    output logic [ptb_pkg::TICK_W-1:0]  o_second_count,
    output logic [ptb_pkg::MASK_W-1:0]  o_fired_mask,
    output logic                        o_alloc_ok,
    output logic [ptb_pkg::ID_W-1:0]    o_assigned_id,
    output logic                        o_was_elapsed
);

    logic                       accept;
    logic                       is_tick;
    logic [ptb_pkg::TICK_W-1:0] ticks_cur;
    logic [ptb_pkg::TICK_W-1:0] ticks_now;
    logic [ptb_pkg::TICK_W-1:0] seconds_now;
    ptb_pkg::t_cell_cmd         cmd;
    ptb_pkg::t_cell_rsp         rsp [NUM_TIMERS];
    logic [NUM_TIMERS:0]        claim;
    logic [NUM_TIMERS-1:0]      grant_vec;

    logic [ptb_pkg::MASK_W-1:0] mask;
    logic [ptb_pkg::ID_W-1:0]   assigned;
    logic                       was;
    logic                       alloc_ok;

    logic                       r_valid;
    logic [ptb_pkg::TICK_W-1:0] r_tick_count;
    logic [ptb_pkg::TICK_W-1:0] r_second_count;
    logic [ptb_pkg::MASK_W-1:0] r_fired_mask;
    logic                       r_alloc_ok;
    logic [ptb_pkg::ID_W-1:0]   r_assigned_id;
    logic                       r_was_elapsed;
    logic                       n_valid;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign is_tick = accept && (i_req_type == ptb_pkg::REQ_TICK);

    ptb_timebase u_timebase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (is_tick),
        .o_ticks_cur (ticks_cur),
        .o_ticks     (ticks_now),
        .o_seconds   (seconds_now)
    );

    always_comb begin
        cmd.do_tick  = is_tick;
        cmd.do_reg   = accept && (i_req_type == ptb_pkg::REQ_REGISTER);
        cmd.do_check = accept && (i_req_type == ptb_pkg::REQ_CHECK);
        cmd.id       = i_timer_id;
        cmd.now      = ticks_now;
        cmd.end_tick = ticks_now + i_duration_ticks;
        cmd.period   = i_duration_ticks;
    end

    assign claim[0] = cmd.do_reg;

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        ptb_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_claim (claim[g]),
            .o_claim (claim[g+1]),
            .o_rsp   (rsp[g])
        );
        assign grant_vec[g] = rsp[g].grant;
    end

    always_comb begin
        mask     = '0;
        assigned = '0;
        was      = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (i < ptb_pkg::MASK_W) begin
                mask[i[ptb_pkg::ID_W-1:0]] = mask[i[ptb_pkg::ID_W-1:0]] | rsp[i].fired;
            end
            if (rsp[i].grant) begin
                assigned = assigned | i[ptb_pkg::ID_W-1:0];
            end
            was = was | rsp[i].was;
        end
        alloc_ok = cmd.do_reg && !claim[NUM_TIMERS];
    end

    assign n_valid = accept || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tick_count   <= ticks_now;
            r_second_count <= seconds_now;
            r_fired_mask   <= mask;
            r_alloc_ok     <= alloc_ok;
            r_assigned_id  <= assigned;
            r_was_elapsed  <= was;
        end
    end

    assign o_valid        = r_valid;
    assign o_tick_count   = r_tick_count;
    assign o_second_count = r_second_count;
    assign o_fired_mask   = r_fired_mask;
    assign o_alloc_ok     = r_alloc_ok;
    assign o_assigned_id  = r_assigned_id;
    assign o_was_elapsed  = r_was_elapsed;

`ifndef NO_ASSERTIONS
    a_grant_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(grant_vec))
        else $error("more than one timer slot claimed by one registration");

    a_ticks_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tick_count == ticks_cur))
        else $error("reported tick count differs from the time base");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_tick |=> (ticks_cur == $past(ticks_cur) + 32'd1))
        else $error("tick item did not advance the tick count by one");

    a_check_no_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == ptb_pkg::REQ_CHECK) |=>
        (o_valid && !o_alloc_ok && o_fired_mask == '0))
        else $error("check item produced an allocation or a fired timer");
`endif

endmodule

### tb/periodic_timer_bank_checker.sv
module periodic_timer_bank_checker
    import ptb_pkg::*;
#(
    parameter int NUM_TIMERS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [ID_W-1:0]   i_timer_id,
    input  logic [TICK_W-1:0] i_duration_ticks,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [TICK_W-1:0] i_tick_count,
    input  logic [TICK_W-1:0] i_second_count,
    input  logic [MASK_W-1:0] i_fired_mask,
    input  logic              i_alloc_ok,
    input  logic [ID_W-1:0]   i_assigned_id,
    input  logic              i_was_elapsed,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TICK_W-1:0] ticks;
        logic [TICK_W-1:0] secs;
        logic [MASK_W-1:0] fired;
        logic              ok;
        logic [ID_W-1:0]   id;
        logic              was;
    } t_timer_result;

    logic [CFG_W-1:0]      incr_per_tick;
    logic [CFG_W-1:0]      secs_threshold;
    logic [TICK_W-1:0]     now_ticks;
    logic [TICK_W-1:0]     now_seconds;
    logic [REM_W-1:0]      remainder;
    logic [NUM_TIMERS-1:0] in_use;
    logic [NUM_TIMERS-1:0] elapsed;
    logic [TICK_W-1:0]     end_tick [NUM_TIMERS];
    logic [TICK_W-1:0]     period [NUM_TIMERS];
    t_timer_result         expected_results [$];
    int                    mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic t_timer_result service_request(logic [1:0] req, logic [ID_W-1:0] id,
                                                      logic [TICK_W-1:0] dur);
        t_timer_result     res;
        logic [TICK_W-1:0] sum;
        logic              found;
        res   = '0;
        found = 1'b0;
        case (req)
            REQ_TICK: begin
                now_ticks = now_ticks + 1'b1;
                sum = TICK_W'(remainder) + TICK_W'(incr_per_tick);
                if (sum >= TICK_W'(secs_threshold)) begin
                    sum         = sum - TICK_W'(secs_threshold);
                    now_seconds = now_seconds + 1'b1;
                end
                remainder = sum[REM_W-1:0];
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (in_use[i] && now_ticks >= end_tick[i]) begin
                        end_tick[i] = end_tick[i] + period[i];
                        elapsed[i]  = 1'b1;
                        if (i < MASK_W) res.fired[i] = 1'b1;
                    end
                end
            end
            REQ_REGISTER: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (!found && !in_use[i]) begin
                        in_use[i]   = 1'b1;
                        elapsed[i]  = 1'b0;
                        end_tick[i] = now_ticks + dur;
                        period[i]   = dur;
                        res.ok      = 1'b1;
                        res.id      = ID_W'(i);
                        found       = 1'b1;
                    end
                end
            end
            REQ_CHECK: begin
                if (int'(id) < NUM_TIMERS) begin
                    res.was     = elapsed[id];
                    elapsed[id] = 1'b0;
                end
            end
            default: ;
        endcase
        res.ticks = now_ticks;
        res.secs  = now_seconds;
        return res;
    endfunction

    task automatic check_field(string field, logic [TICK_W-1:0] want_v,
                               logic [TICK_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_timer_result want;
        if (!i_rst_n) begin
            incr_per_tick  = CPTT_RESET;
            secs_threshold = CPTS_RESET;
            now_ticks      = '0;
            now_seconds    = '0;
            remainder      = '0;
            in_use         = '0;
            elapsed        = '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                end_tick[i] = '0;
                period[i]   = '0;
            end
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual tick_count %0h",
                             $time, i_tick_count);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("tick_count", want.ticks, i_tick_count);
                    check_field("second_count", want.secs, i_second_count);
                    check_field("fired_mask", TICK_W'(want.fired), TICK_W'(i_fired_mask));
                    check_field("alloc_ok", TICK_W'(want.ok), TICK_W'(i_alloc_ok));
                    check_field("assigned_id", TICK_W'(want.id), TICK_W'(i_assigned_id));
                    check_field("was_elapsed", TICK_W'(want.was), TICK_W'(i_was_elapsed));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CPU_TICKS_PER_TICK:   incr_per_tick  = i_cfg_data;
                    CFG_CPU_TICKS_PER_SECOND: secs_threshold = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(
                    service_request(i_req_type, i_timer_id, i_duration_ticks));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### tb/periodic_timer_bank_core_tb.sv
module periodic_timer_bank_core_tb;
    import ptb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]        REQ_UNKNOWN    = 2'd3;
    localparam logic [CIDX_W-1:0] CFG_IDX_UNUSED = 2'd2;
    localparam int                PHASES         = 6;
    localparam int                PHASE_ITEMS    = 180;
    localparam int                LONG_HOLD      = 60;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_req_type;
    logic [ID_W-1:0]   i_timer_id;
    logic [TICK_W-1:0] i_duration_ticks;
    logic              o_valid;
    logic              i_stall;
    logic [TICK_W-1:0] o_tick_count;
    logic [TICK_W-1:0] o_second_count;
    logic [MASK_W-1:0] o_fired_mask;
    logic              o_alloc_ok;
    logic [ID_W-1:0]   o_assigned_id;
    logic              o_was_elapsed;
    int                fail_count;
    int                pending;

    int send_idle_pct = 30;
    int recv_idle_pct = 60;
    bit long_hold     = 1'b0;

    logic [CFG_W-1:0] tick_cfg [PHASES] = '{20'd1, 20'd1000000, 20'hFFFFF, 20'hFFFFF,
                                            20'd250, 20'd0};
    logic [CFG_W-1:0] sec_cfg [PHASES]  = '{20'd1000000, 20'd1000000, 20'd0, 20'd1,
                                            20'd1000, 20'hFFFFF};

    periodic_timer_bank_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_timer_id       (i_timer_id),
        .i_duration_ticks (i_duration_ticks),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_tick_count     (o_tick_count),
        .o_second_count   (o_second_count),
        .o_fired_mask     (o_fired_mask),
        .o_alloc_ok       (o_alloc_ok),
        .o_assigned_id    (o_assigned_id),
        .o_was_elapsed    (o_was_elapsed)
    );

    periodic_timer_bank_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_req_type       (i_req_type),
        .i_timer_id       (i_timer_id),
        .i_duration_ticks (i_duration_ticks),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_tick_count     (o_tick_count),
        .i_second_count   (o_second_count),
        .i_fired_mask     (o_fired_mask),
        .i_alloc_ok       (o_alloc_ok),
        .i_assigned_id    (o_assigned_id),
        .i_was_elapsed    (o_was_elapsed),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    // The receiver honors a long hold request before going back to random stalls.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold = 1'b0;
            end
            i_stall = (int'($urandom_range(99)) < recv_idle_pct);
        end
    end

    task automatic send_item(logic [1:0] req, logic [ID_W-1:0] id, logic [TICK_W-1:0] dur);
        @(negedge i_clk);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_req_type       = req;
        i_timer_id       = id;
        i_duration_ticks = dur;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random();
        int                roll;
        logic [1:0]        req;
        logic [TICK_W-1:0] dur;
        roll = $urandom_range(99);
        if (roll < 50) req = REQ_TICK;
        else if (roll < 65) req = REQ_REGISTER;
        else if (roll < 95) req = REQ_CHECK;
        else req = REQ_UNKNOWN;
        dur = ($urandom_range(9) < 7) ? TICK_W'($urandom_range(40)) : TICK_W'($urandom());
        send_item(req, ID_W'($urandom_range(7)), dur);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_req_type       = REQ_TICK;
        i_timer_id       = '0;
        i_duration_ticks = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: unused slots, unknown requests, zero and wrapping periods.
        send_item(REQ_CHECK, 3'd0, 32'd0);
        send_item(REQ_UNKNOWN, 3'd7, 32'hFFFF_FFFF);
        send_item(REQ_TICK, 3'd0, 32'd0);
        send_item(REQ_REGISTER, 3'd0, 32'd0);
        send_item(REQ_TICK, 3'd0, 32'd0);
        send_item(REQ_REGISTER, 3'd0, 32'hFFFF_FFFF);
        send_item(REQ_TICK, 3'd0, 32'd0);
        send_item(REQ_REGISTER, 3'd0, 32'd3);
        send_item(REQ_REGISTER, 3'd0, 32'd1);
        send_item(REQ_REGISTER, 3'd0, 32'h8000_0000);
        repeat (4) send_item(REQ_TICK, 3'd7, 32'd0);
        send_item(REQ_CHECK, 3'd0, 32'd0);
        send_item(REQ_CHECK, 3'd0, 32'd0);
        send_item(REQ_CHECK, 3'd1, 32'd0);
        send_item(REQ_CHECK, 3'd2, 32'd0);
        send_item(REQ_CHECK, 3'd3, 32'd0);
        send_item(REQ_CHECK, 3'd4, 32'd0);
        send_item(REQ_CHECK, 3'd7, 32'hFFFF_FFFF);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            if (p == 2) begin
                send_idle_pct = 60;
                recv_idle_pct = 30;
            end
            if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_CPU_TICKS_PER_TICK, tick_cfg[p]);
            write_reg(CFG_CPU_TICKS_PER_SECOND, sec_cfg[p]);
            if (p == 3) write_reg(CFG_IDX_UNUSED, 20'h5A5A5);
            if (p == 4) long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 5 && n == PHASE_ITEMS / 2) wait_drained();
                send_random();
            end
        end

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
